// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the positional list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PLI_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: always property");

// Consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property");

`endif

// ----- rtl/pli_pkg.sv -----
// Shared types and constants for the positional list unit
package pli_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_W          = 32;
   localparam int POS_W            = 8;
   localparam int CMD_W            = 2;
   localparam int ECOUNT_W         = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] position;
      value_type        item_value;
   } req_type;

   typedef struct packed {
      logic                ok;
      value_type           read_value;
      logic [ECOUNT_W-1:0] entry_count;
   } rsp_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic             do_insert;
      logic             do_delete;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] count;
      value_type        value;
   } bcast_type;

endpackage

// ----- rtl/pli_cell.sv -----
// One list cell: holds an entry and shifts with its neighbors
module pli_cell #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  pli_pkg::bcast_type bcast,
   input  pli_pkg::value_type left_entry,
   input  pli_pkg::value_type right_entry,
   output pli_pkg::value_type entry,
   output pli_pkg::value_type hit_data
);

   localparam logic [pli_pkg::POS_W:0] IDX = (pli_pkg::POS_W + 1)'(INDEX);

   pli_pkg::value_type entry_ff;
   pli_pkg::value_type entry_in;
   logic [pli_pkg::POS_W:0] pos9;
   logic [pli_pkg::POS_W:0] cnt9;

   assign pos9 = {1'b0, bcast.position};
   assign cnt9 = {1'b0, bcast.count};

   always_comb begin
      entry_in = entry_ff;
      if (bcast.do_insert) begin
         if (IDX == pos9) begin
            entry_in = bcast.value;
         end else if (IDX > pos9 && IDX <= cnt9) begin
            entry_in = left_entry;
         end
      end else if (bcast.do_delete) begin
         if (IDX >= pos9 && (IDX + 1'b1) < cnt9) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign hit_data = (IDX == pos9) ? entry_ff : '0;

endmodule

// ----- rtl/positional_list_insert_delete_unit.sv -----
// Top level: positional list built as a shifting chain of cells
// A request beat accepted at one edge gives its response beat in the next cycle.
// Throughput: one beat per cycle while the response is drained; the affected cells shift or load in the same cycle.
// A new request is taken whenever the response register is empty or drained that cycle.
// Reset clears the entry count and response valid; entries hold no reset value
// and need no clearing pass, since only entries below the count are ever read.
`include "assert_macros.svh"

module positional_list_insert_delete_unit #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pli_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pli_pkg::rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (CNT_W > pli_pkg::ECOUNT_W) ? CNT_W : pli_pkg::ECOUNT_W;
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   pli_pkg::rsp_type   rsp_data_ff;
   pli_pkg::rsp_type   rsp_data_in;

   logic               req_fire;
   logic               list_full;
   logic               ins_ok;
   logic               del_ok;
   logic               rd_ok;
   logic [pli_pkg::POS_W:0] pos9;
   logic [pli_pkg::POS_W:0] cnt9;
   logic [WIDE_W-1:0]  count_wide;
   pli_pkg::bcast_type bcast;
   pli_pkg::value_type cell_entry [CAPACITY];
   pli_pkg::value_type cell_hit   [CAPACITY];
   pli_pkg::value_type rd_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign pos9      = {1'b0, req_data.position};
   assign cnt9      = (pli_pkg::POS_W + 1)'(count_ff);
   assign list_full = (count_ff == CNT_W'(CAPACITY));

   assign ins_ok = (req_data.command == pli_pkg::CMD_INSERT) && (pos9 <= cnt9) && !list_full;
   assign del_ok = (req_data.command == pli_pkg::CMD_DELETE) && (pos9 < cnt9);
   assign rd_ok  = (req_data.command == pli_pkg::CMD_READ) && (pos9 < cnt9);

   assign bcast.do_insert = req_fire && ins_ok;
   assign bcast.do_delete = req_fire && del_ok;
   assign bcast.position  = req_data.position;
   assign bcast.count     = pli_pkg::POS_W'(count_ff);
   assign bcast.value     = req_data.item_value;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      pli_pkg::value_type left_entry;
      pli_pkg::value_type right_entry;

      if (g == 0) begin : g_first
         assign left_entry = req_data.item_value;
      end else begin : g_mid_l
         assign left_entry = cell_entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[g];
      end else begin : g_mid_r
         assign right_entry = cell_entry[g+1];
      end

      pli_cell #(
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .bcast       (bcast),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[g]),
         .hit_data    (cell_hit[g])
      );
   end

   // At most one cell matches the position, so an OR selects it.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | cell_hit[IDX_W'(i)];
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         if (ins_ok) begin
            count_in = count_ff + 1'b1;
         end else if (del_ok) begin
            count_in = count_ff - 1'b1;
         end
         count_wide              = WIDE_W'(count_in);
         rsp_valid_in            = 1'b1;
         rsp_data_in.ok          = ins_ok || del_ok || rd_ok;
         rsp_data_in.read_value  = rd_ok ? rd_data : '0;
         rsp_data_in.entry_count = count_wide[pli_pkg::ECOUNT_W-1:0];
      end else begin
         count_wide = WIDE_W'(count_ff);
         if (rsp_ready) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PLI_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `PLI_ASSERT_NEXT(a_insert_grows, clock, reset, req_fire && ins_ok,
      count_ff == CNT_W'($past(count_ff) + 1'b1))
   `PLI_ASSERT_NEXT(a_delete_shrinks, clock, reset, req_fire && del_ok,
      count_ff == CNT_W'($past(count_ff) - 1'b1))
   `PLI_ASSERT_NEXT(a_fail_holds, clock, reset, req_fire && !ins_ok && !del_ok,
      $stable(count_ff) && !rsp_data.ok == !$past(rd_ok))

endmodule
